// ----- src/psb_pkg.sv -----
// Shared types and constants for the positional sequence buffer.
// No dependencies; imported by the controller, datapath and top level.
package psb_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int POS_W   = 16;
  localparam int OCC_W   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OOB   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    op_e_t                    op;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] element;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;
  } out_word_t;

  typedef struct packed {
    logic exec_op;
    logic emit_empty;
    logic rd_start;
    logic rd_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic rd_last;
  } dp_stat_t;

endpackage

// ----- src/psb_datapath.sv -----
// Datapath: chain of element cells, element count, read index and result register.
// Depends on psb_pkg; driven by psb_ctrl commands.
module psb_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  psb_pkg::in_word_t  in_data,
  input  psb_pkg::dp_cmd_t   cmd,
  output psb_pkg::dp_stat_t  stat,
  output psb_pkg::out_word_t out_data
);
  import psb_pkg::*;

  logic signed [WORD_W-1:0] cells_r   [DEPTH];
  logic signed [WORD_W-1:0] cells_nxt [DEPTH];
  logic signed [WORD_W-1:0] cell_prev [DEPTH];
  logic signed [WORD_W-1:0] cell_next [DEPTH];
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  out_word_t                out_r, out_nxt;

  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   cnt_ext;
  logic [POS_W-1:0] pos_m1;
  logic [IDX_W-1:0] pidx;
  logic             pos_zero;
  logic             ins_oob, del_oob, is_full, is_empty;
  logic             do_ins, do_del;
  status_t          op_status;
  logic             rd_last;

  assign pos_ext  = {1'b0, in_data.position};
  assign cnt_ext  = (POS_W + 1)'(count_r);
  assign pos_m1   = in_data.position - 1'b1;
  assign pidx     = pos_m1[IDX_W-1:0];
  assign pos_zero = (in_data.position == '0);
  assign ins_oob  = pos_zero || (pos_ext > cnt_ext + 1'b1);
  assign del_oob  = pos_zero || (pos_ext > cnt_ext);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign rd_last  = ((CNT_W'(rd_idx_r) + 1'b1) == count_r);

  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    op_status = ST_OK;
    if (in_data.op == OP_INSERT) begin
      if (ins_oob) begin
        op_status = ST_OOB;
      end else if (is_full) begin
        op_status = ST_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end else begin
      if (is_empty) begin
        op_status = ST_EMPTY;
      end else if (del_oob) begin
        op_status = ST_OOB;
      end else begin
        do_del = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
    if (g == 0) begin : g_first
      assign cell_prev[g] = cells_r[g];
    end else begin : g_rest
      assign cell_prev[g] = cells_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_lastc
      assign cell_next[g] = cells_r[g];
    end else begin : g_body
      assign cell_next[g] = cells_r[g+1];
    end
  end

  // shift every cell at once
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
      if (cmd.exec_op && do_ins) begin
        if (IDX_W'(i) == pidx) begin
          cells_nxt[i] = in_data.value;
        end else if ((IDX_W'(i) > pidx) && (CNT_W'(i) <= count_r)) begin
          cells_nxt[i] = cell_prev[i];
        end
      end else if (cmd.exec_op && do_del) begin
        if ((IDX_W'(i) >= pidx) && ((CNT_W'(i) + 1'b1) < count_r)) begin
          cells_nxt[i] = cell_next[i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.exec_op && do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.exec_op && do_del) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_emit) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.exec_op) begin
      out_nxt.status    = op_status;
      out_nxt.element   = '0;
      out_nxt.last      = 1'b1;
      out_nxt.occupancy = OCC_W'(count_nxt);
    end else if (cmd.emit_empty) begin
      out_nxt.status    = ST_EMPTY;
      out_nxt.element   = '0;
      out_nxt.last      = 1'b1;
      out_nxt.occupancy = OCC_W'(count_r);
    end else if (cmd.rd_emit) begin
      out_nxt.status    = ST_OK;
      out_nxt.element   = cells_r[rd_idx_r];
      out_nxt.last      = rd_last;
      out_nxt.occupancy = OCC_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
    end else begin
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    out_r   <= out_nxt;
  end

  assign stat.empty   = is_empty;
  assign stat.rd_last = rd_last;
  assign out_data     = out_r;

endmodule

// ----- src/psb_ctrl.sv -----
// Controller: accepts words, sequences read-out and owns the result valid flag.
// Depends on psb_pkg; commands psb_datapath.
module psb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psb_pkg::op_e_t    in_op,
  output logic              out_valid,
  input  logic              out_stall,
  input  psb_pkg::dp_stat_t stat,
  output psb_pkg::dp_cmd_t  cmd
);
  import psb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   take;

  assign out_free = !out_valid_r || !out_stall;
  assign take     = (state_r == S_IDLE) && in_valid && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take && (in_op == OP_READ) && !stat.empty) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (out_free && stat.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (in_op)
            OP_INSERT, OP_DELETE: cmd.exec_op = 1'b1;
            OP_READ: begin
              cmd.emit_empty = stat.empty;
              cmd.rd_start   = !stat.empty;
            end
            default: cmd = '0;
          endcase
        end
      end
      S_READ: begin
        cmd.rd_emit = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = cmd.exec_op || cmd.emit_empty || cmd.rd_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign out_valid = out_valid_r;

endmodule

// ----- src/positional_sequence_buffer.sv -----
// Top level of the positional sequence buffer: controller plus datapath.
// Depends on psb_pkg, psb_ctrl and psb_datapath.
//
//   channel | ports                          | carries
//   input   | in_valid, in_stall, in_data    | op, value, position
//   result  | out_valid, out_stall, out_data | status, element, last, occupancy
//
// Insert and delete shift all cells at once and register one status word.
// A read of a non-empty store holds the input and emits one word per cycle
// while the result is not stalled, from the read index into the cell chain.
// Unused op codes are dropped. Reset empties the store at once; cell contents
// stay undefined until written. A stalled result holds in the output register;
// a new word is taken as the old result leaves.
module positional_sequence_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psb_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output psb_pkg::out_word_t out_data
);
  import psb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  psb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  psb_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
